>>> rtl/gmc_pkg.sv
// shared widths, codes and control types of the global minimum cut search
package gmc_pkg;

    localparam int NODE_W   = 6;
    localparam int WEIGHT_W = 16;
    localparam int CUT_W    = 27;
    localparam int CNT_W    = 7;

    localparam logic [CUT_W-1:0] CUT_ALL_ONES = {CUT_W{1'b1}};
    localparam logic [CNT_W-1:0] MIN_NODES    = CNT_W'(2);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } opcode_t;

    // command from the search engine to the result stage
    typedef struct packed {
        logic             start;
        logic [CUT_W-1:0] cut;
    } emit_cmd_t;

endpackage

>>> rtl/gmc_if.sv
// valid/ready channel interfaces for search items and result beats
interface gmc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [gmc_pkg::NODE_W-1:0]    row;
    logic [gmc_pkg::NODE_W-1:0]    col;
    logic [gmc_pkg::WEIGHT_W-1:0]  weight;

    modport source (output valid, output opcode, output row, output col, output weight,
                    input ready);
    modport sink   (input valid, input opcode, input row, input col, input weight,
                    output ready);
endinterface

interface gmc_out_if;
    logic                          valid;
    logic                          ready;
    logic [gmc_pkg::NODE_W-1:0]    node;
    logic [gmc_pkg::CUT_W-1:0]     cut_weight;
    logic                          last;

    modport source (output valid, output node, output cut_weight, output last,
                    input ready);
    modport sink   (input valid, input node, input cut_weight, input last,
                    output ready);
endinterface

>>> rtl/gmc_emit.sv
// result stage: walks the chosen side in ascending order into an output register
module gmc_emit #(
    parameter int SIDE_W = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gmc_pkg::emit_cmd_t  cmd,
    input  logic [SIDE_W-1:0]   side,
    output logic                busy,
    gmc_out_if.source           out_ch
);

    localparam int IW = (SIDE_W > 1) ? $clog2(SIDE_W) : 1;

    logic [SIDE_W-1:0]             left_reg, left_next;
    logic [IW-1:0]                 e_reg, e_next;
    logic [gmc_pkg::CUT_W-1:0]     cut_reg, cut_next;
    logic                          ov_reg, ov_next;
    logic [gmc_pkg::NODE_W-1:0]    node_reg, node_next;
    logic                          last_reg, last_next;
    logic [SIDE_W-1:0]             e_bit;
    logic                          slot_free;

    assign busy      = (left_reg != '0);
    assign slot_free = !ov_reg || out_ch.ready;
    assign e_bit     = SIDE_W'(1) << e_reg;

    always_comb
    begin
        left_next = left_reg;
        e_next    = e_reg;
        cut_next  = cut_reg;
        ov_next   = ov_reg && !out_ch.ready;
        node_next = node_reg;
        last_next = last_reg;
        if (cmd.start)
        begin
            left_next = side;
            e_next    = '0;
            cut_next  = cmd.cut;
        end
        else if (busy && slot_free)
        begin
            if (left_reg[e_reg])
            begin
                ov_next   = 1'b1;
                node_next = gmc_pkg::NODE_W'(e_reg);
                last_next = ((left_reg & ~e_bit) == '0);
                left_next = left_reg & ~e_bit;
            end
            e_next = e_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            e_reg    <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            e_reg    <= e_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cut_reg  <= cut_next;
        node_reg <= node_next;
        last_reg <= last_next;
    end

    assign out_ch.valid      = ov_reg;
    assign out_ch.node       = node_reg;
    assign out_ch.cut_weight = cut_reg;
    assign out_ch.last       = last_reg;

    // a new side is only handed over once the previous one has been fully moved into the output register
    assert property (@(posedge clk) disable iff (!rst_n) cmd.start |-> !busy)
        else $error("emit start while busy");

endmodule

>>> rtl/global_min_cut_search.sv
// top level: edge store, working matrix and phase sequencer of the minimum cut search
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        opcode, row, col, weight
//  out_ch    out  valid/ready        node, cut_weight, last
//  cfg       in   cfg_we (no ready)  cfg_wdata = node_count
//
//  loads stream one beat per cycle while idle
//  a search copies the n*n store entries, then per phase with r live supernodes
//  runs a setup step, (r-1) sweeps each with a drain and a selection step, one
//  merge decision and, if r > 2, a merge over the n indices that writes row and
//  column in turn through the single write port of the working matrix memory
//  no item is taken while a search runs; the result stage scans one node index
//  per cycle while its output slot is free, so beats leave at most one per cycle
//  reset clears control only; both memories start undefined
module global_min_cut_search #(
    parameter int MAX_NODES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gmc_pkg::CNT_W-1:0]   cfg_wdata,
    gmc_in_if.sink                      in_ch,
    gmc_out_if.source                   out_ch
);

    localparam int IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = gmc_pkg::CUT_W;
    localparam int KW    = gmc_pkg::CNT_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_COPY   = 11'b000_0000_0010,
        S_PHASE  = 11'b000_0000_0100,
        S_SWEEP  = 11'b000_0000_1000,
        S_DRAIN  = 11'b000_0001_0000,
        S_SELECT = 11'b000_0010_0000,
        S_PEND   = 11'b000_0100_0000,
        S_MRD    = 11'b000_1000_0000,
        S_MWR1   = 11'b001_0000_0000,
        S_MWR2   = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } state_t;

    // loaded weights and the working copy; the diagonal of the copy holds
    // the attachment weight of each supernode during a phase
    logic [CW-1:0] estore [DEPTH];
    logic [CW-1:0] wmem   [DEPTH];

    state_t               state_reg, state_next;
    logic [KW-1:0]        cfg_reg, cfg_next;
    logic [IW-1:0]        nm1_reg, nm1_next;
    logic [KW-1:0]        r_reg, r_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [IW-1:0]        ci_reg, ci_next, cj_reg, cj_next;
    logic [AW-1:0]        cwa_reg, cwa_next;
    logic                 cdiag_reg, cdiag_next;
    logic                 cv_reg, cv_next;
    logic [IW-1:0]        rj_reg, rj_next, pj_reg, pj_next;
    logic                 pv_reg, pv_next;
    logic [IW-1:0]        s_reg, s_next;
    logic                 base0_reg, base0_next;
    logic                 found_reg, found_next;
    logic [CW-1:0]        max_reg, max_next;
    logic [IW-1:0]        maxj_reg, maxj_next;
    logic [MAX_NODES-1:0] inphase_reg, inphase_next;
    logic [MAX_NODES-1:0] active_reg, active_next;
    logic [IW-1:0]        group_reg [MAX_NODES];
    logic [IW-1:0]        group_next [MAX_NODES];
    logic [CW-1:0]        best_cut_reg, best_cut_next;
    logic [MAX_NODES-1:0] best_side_reg, best_side_next;
    logic [CW-1:0]        phase_cut_reg, phase_cut_next;
    logic [IW-1:0]        prev_reg, prev_next, last_reg, last_next;
    logic [IW-1:0]        mj_reg, mj_next;
    logic [CW-1:0]        v_reg, v_next;

    logic [CW-1:0]        estore_q, qa, qb;
    logic [AW-1:0]        est_ra, ra_a, ra_b, wa;
    logic [CW-1:0]        wd;
    logic                 we;
    logic                 load_ok;
    logic [KW-1:0]        nsat;
    logic [CW:0]          sum_ab;
    logic [CW-1:0]        sval;
    logic                 cand, mskip;
    logic [IW-1:0]        clo, chi;
    logic                 emit_busy;
    gmc_pkg::emit_cmd_t   emit_cmd;

    // ---- edge store: loads write, the copy pass reads ----
    assign load_ok = in_ch.valid && in_ch.ready && (in_ch.opcode == gmc_pkg::OP_LOAD)
                     && (in_ch.row != in_ch.col)
                     && ({1'b0, in_ch.row} < KW'(MAX_NODES))
                     && ({1'b0, in_ch.col} < KW'(MAX_NODES));

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            if (in_ch.row < in_ch.col)
                estore[{in_ch.row[IW-1:0], in_ch.col[IW-1:0]}] <= CW'(in_ch.weight);
            else
                estore[{in_ch.col[IW-1:0], in_ch.row[IW-1:0]}] <= CW'(in_ch.weight);
        end
        estore_q <= estore[est_ra];
    end

    // the store holds one entry per unordered pair, lower index first
    assign clo    = (ci_reg < cj_reg) ? ci_reg : cj_reg;
    assign chi    = (ci_reg < cj_reg) ? cj_reg : ci_reg;
    assign est_ra = {clo, chi};

    // ---- working matrix: two read ports, one write port ----
    always_ff @(posedge clk)
    begin
        if (we)
            wmem[wa] <= wd;
        qa <= wmem[ra_a];
        qb <= wmem[ra_b];
    end

    // port a: attachment (diagonal) in sweeps, row prev in merges
    // port b: row of the newly added supernode in sweeps, row last in merges
    assign ra_a = (state_reg == S_SWEEP) ? {rj_reg, rj_reg} : {prev_reg, mj_reg};
    assign ra_b = (state_reg == S_SWEEP) ? {s_reg, rj_reg}  : {last_reg, mj_reg};

    assign sum_ab = {1'b0, qa} + {1'b0, qb};
    assign sval   = base0_reg ? qb : sum_ab[CW-1:0];
    assign cand   = active_reg[pj_reg] && !inphase_reg[pj_reg];
    assign mskip  = !active_reg[mj_reg] || (mj_reg == prev_reg) || (mj_reg == last_reg);

    // write port select; the passes never overlap in time
    always_comb
    begin
        we = 1'b0;
        wa = cwa_reg;
        wd = cdiag_reg ? '0 : estore_q;
        priority if (cv_reg)
        begin
            we = 1'b1;
        end
        else if (pv_reg && cand)
        begin
            we = 1'b1;
            wa = {pj_reg, pj_reg};
            wd = sval;
        end
        else if (state_reg == S_MWR1)
        begin
            we = 1'b1;
            wa = {prev_reg, mj_reg};
            wd = sum_ab[CW-1:0];
        end
        else if (state_reg == S_MWR2)
        begin
            we = 1'b1;
            wa = {mj_reg, prev_reg};
            wd = v_reg;
        end
        else
        begin
            we = 1'b0;
        end
    end

    // node count saturated to the legal range
    always_comb
    begin
        priority if (cfg_reg < gmc_pkg::MIN_NODES)
            nsat = gmc_pkg::MIN_NODES;
        else if (cfg_reg > KW'(MAX_NODES))
            nsat = KW'(MAX_NODES);
        else
            nsat = cfg_reg;
    end

    assign in_ch.ready = (state_reg == S_IDLE);

    // ---- sequencer ----
    always_comb
    begin
        state_next     = state_reg;
        cfg_next       = cfg_we ? cfg_wdata : cfg_reg;
        nm1_next       = nm1_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        cwa_next       = {ci_reg, cj_reg};
        cdiag_next     = (ci_reg == cj_reg);
        cv_next        = (state_reg == S_COPY);
        rj_next        = rj_reg;
        pj_next        = rj_reg;
        pv_next        = (state_reg == S_SWEEP);
        s_next         = s_reg;
        base0_next     = base0_reg;
        found_next     = found_reg;
        max_next       = max_reg;
        maxj_next      = maxj_reg;
        inphase_next   = inphase_reg;
        active_next    = active_reg;
        group_next     = group_reg;
        best_cut_next  = best_cut_reg;
        best_side_next = best_side_reg;
        phase_cut_next = phase_cut_reg;
        prev_next      = prev_reg;
        last_next      = last_reg;
        mj_next        = mj_reg;
        v_next         = v_reg;
        emit_cmd.start = 1'b0;
        emit_cmd.cut   = best_cut_reg;

        // sweep data stage: accumulate attachment and track the strict maximum
        if (pv_reg && cand)
        begin
            if (!found_reg || (sval > max_reg))
            begin
                found_next = 1'b1;
                max_next   = sval;
                maxj_next  = pj_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && (in_ch.opcode == gmc_pkg::OP_SEARCH))
                begin
                    nm1_next       = IW'(nsat - KW'(1));
                    r_next         = nsat;
                    ci_next        = '0;
                    cj_next        = '0;
                    best_cut_next  = gmc_pkg::CUT_ALL_ONES;
                    best_side_next = '0;
                    for (int i = 0; i < MAX_NODES; i++)
                    begin
                        group_next[i]  = IW'(i);
                        active_next[i] = (KW'(i) < nsat);
                    end
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                cj_next = cj_reg + IW'(1);
                if (cj_reg == nm1_reg)
                begin
                    cj_next = '0;
                    ci_next = ci_reg + IW'(1);
                    if (ci_reg == nm1_reg)
                        state_next = S_PHASE;
                end
            end
            S_PHASE:
            begin
                // set grows from supernode 0
                inphase_next = MAX_NODES'(1);
                found_next   = 1'b0;
                s_next       = '0;
                base0_next   = 1'b1;
                k_next       = KW'(1);
                prev_next    = '0;
                last_next    = '0;
                rj_next      = '0;
                state_next   = S_SWEEP;
            end
            S_SWEEP:
            begin
                rj_next = rj_reg + IW'(1);
                if (rj_reg == nm1_reg)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_SELECT;
            end
            S_SELECT:
            begin
                inphase_next[maxj_reg] = 1'b1;
                prev_next      = last_reg;
                last_next      = maxj_reg;
                phase_cut_next = max_reg;
                if (k_reg < (r_reg - KW'(1)))
                begin
                    s_next     = maxj_reg;
                    base0_next = 1'b0;
                    found_next = 1'b0;
                    k_next     = k_reg + KW'(1);
                    rj_next    = '0;
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_PEND;
                end
            end
            S_PEND:
            begin
                // first strictly smaller cut of the phase wins
                if (phase_cut_reg < best_cut_reg)
                begin
                    best_cut_next = phase_cut_reg;
                    for (int i = 0; i < MAX_NODES; i++)
                        best_side_next[i] = (group_reg[i] == last_reg);
                end
                for (int i = 0; i < MAX_NODES; i++)
                    if (group_reg[i] == last_reg)
                        group_next[i] = prev_reg;
                active_next[last_reg] = 1'b0;
                r_next  = r_reg - KW'(1);
                mj_next = '0;
                if ((r_reg - KW'(1)) > KW'(1))
                    state_next = S_MRD;
                else
                    state_next = S_EMIT;
            end
            S_MRD:
            begin
                if (mskip)
                begin
                    mj_next = mj_reg + IW'(1);
                    if (mj_reg == nm1_reg)
                        state_next = S_PHASE;
                end
                else
                begin
                    state_next = S_MWR1;
                end
            end
            S_MWR1:
            begin
                v_next     = sum_ab[CW-1:0];
                state_next = S_MWR2;
            end
            S_MWR2:
            begin
                mj_next = mj_reg + IW'(1);
                if (mj_reg == nm1_reg)
                    state_next = S_PHASE;
                else
                    state_next = S_MRD;
            end
            S_EMIT:
            begin
                if (!emit_busy)
                begin
                    emit_cmd.start = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cfg_reg   <= gmc_pkg::MIN_NODES;
            cv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cfg_reg   <= cfg_next;
            cv_reg    <= cv_next;
            pv_reg    <= pv_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nm1_reg       <= nm1_next;
        r_reg         <= r_next;
        k_reg         <= k_next;
        ci_reg        <= ci_next;
        cj_reg        <= cj_next;
        cwa_reg       <= cwa_next;
        cdiag_reg     <= cdiag_next;
        rj_reg        <= rj_next;
        pj_reg        <= pj_next;
        s_reg         <= s_next;
        base0_reg     <= base0_next;
        max_reg       <= max_next;
        maxj_reg      <= maxj_next;
        inphase_reg   <= inphase_next;
        active_reg    <= active_next;
        group_reg     <= group_next;
        best_cut_reg  <= best_cut_next;
        best_side_reg <= best_side_next;
        phase_cut_reg <= phase_cut_next;
        prev_reg      <= prev_next;
        last_reg      <= last_next;
        mj_reg        <= mj_next;
        v_reg         <= v_next;
    end

    gmc_emit #(
        .SIDE_W (MAX_NODES)
    ) u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (emit_cmd),
        .side   (best_side_reg),
        .busy   (emit_busy),
        .out_ch (out_ch)
    );

    // every selection step has a candidate to add
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SELECT) |-> found_reg)
        else $error("selection without candidate");

    // the merged pair is two distinct supernodes
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PEND) |-> (last_reg != prev_reg))
        else $error("merge of a supernode into itself");

    // sweep and copy writes never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        cv_reg |-> !pv_reg)
        else $error("copy and sweep write overlap");

endmodule
